[src/dmpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpd_pkg
// Shared types, codes and constants of the dual motor PD speed regulator.
// ----------------------------------------------------------------------------
package dmpd_pkg;

  // Default sizes.
  localparam int SPEED_LEVELS_DEF = 16;
  localparam int MOTOR_COUNT_DEF  = 2;

  // Target pulse counts per speed code.
  localparam int TABLE_LEN = 16;
  localparam logic [7:0] SPEED_TABLE [TABLE_LEN] = '{
    8'd0, 8'd10, 8'd20, 8'd28, 8'd36, 8'd46, 8'd54, 8'd66,
    8'd74, 8'd84, 8'd92, 8'd102, 8'd112, 8'd122, 8'd130, 8'd140
  };

  // Action codes of an input word.
  localparam logic [1:0] ACT_EDGE  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_SPEED = 2'd2;
  localparam logic [1:0] ACT_DIR   = 2'd3;

  // Direction codes.
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BWD  = 2'd2;

  // Bridge pin patterns.
  localparam logic [1:0] PINS_OFF   = 2'd0;
  localparam logic [1:0] PINS_FWD   = 2'd1;
  localparam logic [1:0] PINS_BWD   = 2'd2;
  localparam logic [1:0] PINS_BRAKE = 2'd3;

  // Configuration register map.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 4'd1;
  localparam logic [7:0] PROP_GAIN_RST  = 8'd60;
  localparam logic [7:0] DERIV_GAIN_RST = 8'd30;

  // Duty limit.
  localparam logic [7:0] DUTY_MAX = 8'hff;

  // Division by 100: a magnitude below 2^24 is shifted right by two and then
  // multiplied by the rounded-up reciprocal of 25 scaled by 2^28. The shifted
  // magnitude is split into two halves of eleven bits, one partial product each.
  localparam int DIV_MAG_W   = 24;
  localparam int DIV_Y_W     = 22;
  localparam int DIV_HALF_W  = 11;
  localparam int DIV_RECIP_W = 24;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 24'd10737419;
  localparam int DIV_SHIFT   = 28;
  localparam int DIV_PP_W    = DIV_HALF_W + DIV_RECIP_W;
  localparam int DIV_SUM_W   = DIV_PP_W + DIV_HALF_W;
  localparam int DIV_Q_W     = DIV_SUM_W - DIV_SHIFT;

  // Regulator gains.
  typedef struct packed {
    logic [7:0] prop;
    logic [7:0] deriv;
  } gains_t;

  // One motor's operands for the regulator.
  typedef struct packed {
    logic               run;
    logic [15:0]        count;
    logic [7:0]         target;
    logic signed [15:0] perr;
    logic [7:0]         duty;
  } calc_req_t;

  // One motor's updated state from the regulator.
  typedef struct packed {
    logic [7:0]         duty;
    logic signed [15:0] perr;
  } calc_rsp_t;

  // Bridge pins for a direction; anything but forward or backward brakes.
  function automatic logic [1:0] pins_of(input logic [1:0] dir);
    logic [1:0] pins;
    case (dir)
      DIR_FWD: pins = PINS_FWD;
      DIR_BWD: pins = PINS_BWD;
      default: pins = PINS_BRAKE;
    endcase
    return pins;
  endfunction

endpackage

[src/dual_motor_pd_speed_regulator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_pd_speed_regulator_core
// Speed regulator for up to MOTOR_COUNT motors with encoder feedback. Targets
// and previous errors live in two small synchronous memories; a tick walks
// the motors through one shared PD pipeline that reads and writes them back.
// ----------------------------------------------------------------------------
// Flow: the result word of an edge or command is registered into the output
// word, or into the skid stage while the output is held; edges and commands
// are taken one per cycle while the input is not stalled. A tick issues one
// motor per cycle into the memory read and PD pipeline and keeps the input
// stalled until the last motor's response has come back.
// Reset (synchronous): gains 60 and 30, all motors stopped with zero counts
// and duty, and the memory valid bits cleared so entries read as zero.
module dual_motor_pd_speed_regulator_core #(
  parameter int SPEED_LEVELS = dmpd_pkg::SPEED_LEVELS_DEF,
  parameter int MOTOR_COUNT  = dmpd_pkg::MOTOR_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     action,
  input  logic                           motor_select,
  input  logic [7:0]                     command_value,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     duty_first,
  output logic [7:0]                     duty_second,
  output logic [1:0]                     dir_first,
  output logic [1:0]                     dir_second,
  output logic [1:0]                     bridge_pins_first,
  output logic [1:0]                     bridge_pins_second,
  output logic [1:0]                     pwm_enable_mask,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dmpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MOTOR_COUNT - 1);
  localparam bit SECOND_OK = (MOTOR_COUNT > 1);

  typedef struct packed {
    logic [7:0] duty_a;
    logic [7:0] duty_b;
    logic [1:0] dir_a;
    logic [1:0] dir_b;
    logic [1:0] pins_a;
    logic [1:0] pins_b;
    logic [1:0] mask;
  } res_t;

  // Configuration registers; writes are always taken.
  dmpd_pkg::gains_t gains;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop  <= dmpd_pkg::PROP_GAIN_RST;
      gains.deriv <= dmpd_pkg::DERIV_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dmpd_pkg::REG_PROP_GAIN:  gains.prop  <= cfg_data;
        dmpd_pkg::REG_DERIV_GAIN: gains.deriv <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input acceptance and decode.
  logic             busy;
  logic             skid_valid;
  logic             in_acc;
  logic             sel_ok;
  logic [IDX_W-1:0] sel_idx;
  logic             is_tick;
  logic             start_cmd;
  logic [1:0]       new_dir;

  assign in_stall  = skid_valid || busy;
  assign in_acc    = in_valid && !in_stall;
  assign is_tick   = (action == dmpd_pkg::ACT_TICK);
  assign sel_ok    = !motor_select || SECOND_OK;
  assign sel_idx   = IDX_W'(motor_select);
  assign start_cmd = (command_value == 8'(dmpd_pkg::DIR_FWD))
                  || (command_value == 8'(dmpd_pkg::DIR_BWD));
  assign new_dir   = start_cmd ? command_value[1:0] : dmpd_pkg::DIR_STOP;

  // Speed code to table index: remainder by SPEED_LEVELS through a
  // reciprocal multiply, clamped to the last table entry.
  localparam logic [16:0] SPD_RECIP = 17'((65536 + SPEED_LEVELS - 1) / SPEED_LEVELS);
  localparam logic [7:0]  SPD_LVL   = 8'(SPEED_LEVELS);
  localparam logic [7:0]  TBL_LAST  = 8'(dmpd_pkg::TABLE_LEN - 1);

  logic [24:0] spd_prod;
  logic [7:0]  spd_quot;
  logic [15:0] spd_back;
  logic [7:0]  spd_rem0;
  logic [7:0]  spd_rem;
  logic [3:0]  spd_idx;
  logic [7:0]  spd_target;

  always_comb begin
    spd_prod = 25'(command_value) * 25'(SPD_RECIP);
    spd_quot = spd_prod[23:16];
    spd_back = 16'(spd_quot) * 16'(SPD_LVL);
    spd_rem0 = command_value - spd_back[7:0];
    spd_rem  = (spd_rem0 >= SPD_LVL) ? spd_rem0 - SPD_LVL : spd_rem0;
    spd_idx  = (spd_rem > TBL_LAST) ? TBL_LAST[3:0] : spd_rem[3:0];
    spd_target = dmpd_pkg::SPEED_TABLE[spd_idx];
  end

  // Tick sequencer and regulator hand-off.
  logic                seq_active;
  logic [IDX_W-1:0]    seq_idx;
  logic                tick_done;
  logic                iss_valid;
  logic [IDX_W-1:0]    iss_idx;
  logic                iss_run;
  logic [15:0]         iss_count;
  logic [7:0]          iss_duty;
  logic                rsp_valid;
  logic [IDX_W-1:0]    rsp_idx;
  dmpd_pkg::calc_rsp_t rsp;
  logic                cnt_clear_all;

  assign cnt_clear_all = rsp_valid && (rsp_idx == LAST_IDX);

  // Per-motor lanes: pulse counts, directions and duties.
  logic [15:0] cnt      [MOTOR_COUNT];
  logic [1:0]  dir      [MOTOR_COUNT];
  logic [1:0]  dir_next [MOTOR_COUNT];
  logic [7:0]  duty     [MOTOR_COUNT];

  always_comb begin
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      dir_next[k] = dir[k];
      if (in_acc && sel_ok && (action == dmpd_pkg::ACT_DIR) && (sel_idx == IDX_W'(k))) begin
        dir_next[k] = new_dir;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        cnt[k]  <= 16'd0;
        dir[k]  <= dmpd_pkg::DIR_STOP;
        duty[k] <= 8'd0;
      end
    end else begin
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        if (cnt_clear_all) begin
          cnt[k] <= 16'd0;
        end else if (in_acc && sel_ok && (sel_idx == IDX_W'(k))) begin
          if ((action == dmpd_pkg::ACT_EDGE) && (dir[k] != dmpd_pkg::DIR_STOP)) begin
            cnt[k] <= cnt[k] + 16'd1;
          end else if ((action == dmpd_pkg::ACT_DIR) && start_cmd) begin
            cnt[k] <= 16'd0;
          end
        end
        dir[k] <= dir_next[k];
        if (rsp_valid && (rsp_idx == IDX_W'(k))) begin
          duty[k] <= rsp.duty;
        end
      end
    end
  end

  // Target and previous-error memories with reset-cleared valid bits.
  logic [7:0]             tgt_mem  [MOTOR_COUNT];
  logic signed [15:0]     perr_mem [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] tgt_vld;
  logic [MOTOR_COUNT-1:0] perr_vld;
  logic [7:0]             tgt_rd;
  logic signed [15:0]     perr_rd;
  logic                   tgt_vld_rd;
  logic                   perr_vld_rd;
  logic                   spd_wr;

  assign spd_wr = in_acc && sel_ok && (action == dmpd_pkg::ACT_SPEED);

  always_ff @(posedge clk) begin
    if (spd_wr) begin
      tgt_mem[sel_idx] <= spd_target;
    end
    if (rsp_valid) begin
      perr_mem[rsp_idx] <= rsp.perr;
    end
    if (seq_active) begin
      tgt_rd  <= tgt_mem[seq_idx];
      perr_rd <= perr_mem[seq_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_vld     <= '0;
      perr_vld    <= '0;
      tgt_vld_rd  <= 1'b0;
      perr_vld_rd <= 1'b0;
    end else begin
      if (spd_wr) begin
        tgt_vld[sel_idx] <= 1'b1;
      end
      if (rsp_valid) begin
        perr_vld[rsp_idx] <= 1'b1;
      end
      if (seq_active) begin
        tgt_vld_rd  <= tgt_vld[seq_idx];
        perr_vld_rd <= perr_vld[seq_idx];
      end
    end
  end

  // Sequencer: a tick locks the input and issues one motor per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      seq_active <= 1'b0;
      seq_idx    <= '0;
      tick_done  <= 1'b0;
      iss_valid  <= 1'b0;
    end else begin
      tick_done <= cnt_clear_all;
      iss_valid <= seq_active;
      if (in_acc && is_tick) begin
        busy       <= 1'b1;
        seq_active <= 1'b1;
        seq_idx    <= '0;
      end else if (seq_active) begin
        seq_idx <= seq_idx + IDX_W'(1);
        if (seq_idx == LAST_IDX) begin
          seq_active <= 1'b0;
        end
      end
      if (tick_done) begin
        busy <= 1'b0;
      end
    end
  end

  // Lane operands captured alongside the memory read.
  always_ff @(posedge clk) begin
    iss_idx   <= seq_idx;
    iss_run   <= (dir[seq_idx] != dmpd_pkg::DIR_STOP);
    iss_count <= cnt[seq_idx];
    iss_duty  <= duty[seq_idx];
  end

  dmpd_pkg::calc_req_t req;

  assign req.run    = iss_run;
  assign req.count  = iss_count;
  assign req.target = tgt_vld_rd ? tgt_rd : 8'd0;
  assign req.perr   = perr_vld_rd ? perr_rd : 16'sd0;
  assign req.duty   = iss_duty;

  dmpd_pd_calc #(
    .IDX_W (IDX_W)
  ) u_calc (
    .clk       (clk),
    .rst       (rst),
    .gains     (gains),
    .req_valid (iss_valid),
    .req_idx   (iss_idx),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_idx   (rsp_idx),
    .rsp       (rsp)
  );

  // Result word: state after the accepted word or after a finished tick.
  logic       result_fire;
  logic [7:0] duty_b;
  logic [1:0] dir_b;
  res_t       res;

  assign result_fire = (in_acc && !is_tick) || tick_done;

  if (MOTOR_COUNT > 1) begin : g_second
    assign duty_b = duty[1];
    assign dir_b  = dir_next[1];
  end else begin : g_single
    assign duty_b = 8'd0;
    assign dir_b  = dmpd_pkg::DIR_STOP;
  end

  always_comb begin
    res.duty_a  = duty[0];
    res.duty_b  = duty_b;
    res.dir_a   = dir_next[0];
    res.dir_b   = dir_b;
    res.pins_a  = dmpd_pkg::pins_of(dir_next[0]);
    res.pins_b  = SECOND_OK ? dmpd_pkg::pins_of(dir_b) : dmpd_pkg::PINS_OFF;
    res.mask[0] = (dir_next[0] != dmpd_pkg::DIR_STOP);
    res.mask[1] = (dir_b != dmpd_pkg::DIR_STOP);
  end

  // Output register with a skid stage behind it.
  res_t out_word;
  res_t skid_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= result_fire;
      end else begin
        out_valid <= result_fire;
      end
    end else if (result_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_word  <= skid_word;
        skid_word <= res;
      end else begin
        out_word <= res;
      end
    end else if (result_fire) begin
      skid_word <= res;
    end
  end

  assign duty_first         = out_word.duty_a;
  assign duty_second        = out_word.duty_b;
  assign dir_first          = out_word.dir_a;
  assign dir_second         = out_word.dir_b;
  assign bridge_pins_first  = out_word.pins_a;
  assign bridge_pins_second = out_word.pins_b;
  assign pwm_enable_mask    = out_word.mask;

  // The skid stage only fills behind a held output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without an output word");

  // No result may arrive while the skid stage is occupied.
  a_no_skid_overrun: assert property (@(posedge clk) disable iff (rst)
    !(skid_valid && result_fire))
    else $error("result word produced with the skid stage full");

  // An accepted tick starts the motor walk and locks the input.
  a_tick_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_tick) |=> (busy && seq_active))
    else $error("tick accepted without starting the regulator walk");

  // Regulator responses only come back during a tick.
  a_rsp_in_tick: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> busy)
    else $error("regulator response outside a tick");

  // A finished tick has issued every motor.
  a_done_after_walk: assert property (@(posedge clk) disable iff (rst)
    tick_done |-> (!seq_active && busy))
    else $error("tick finished while motors are still being issued");

endmodule

[src/dmpd_pd_calc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpd_pd_calc
// Four-stage PD arithmetic for one motor per cycle: error, products, division
// by 100 through a reciprocal, and the saturated duty update.
// ----------------------------------------------------------------------------
module dmpd_pd_calc #(
  parameter int IDX_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  dmpd_pkg::gains_t    gains,
  input  logic                req_valid,
  input  logic [IDX_W-1:0]    req_idx,
  input  dmpd_pkg::calc_req_t req,
  output logic                rsp_valid,
  output logic [IDX_W-1:0]    rsp_idx,
  output dmpd_pkg::calc_rsp_t rsp
);

  // Stage 1: saturated error and error difference.
  logic signed [16:0] diff;
  logic signed [15:0] err;
  logic signed [16:0] dd;

  logic               s1_valid;
  logic [IDX_W-1:0]   s1_idx;
  logic               s1_run;
  logic [7:0]         s1_duty;
  logic signed [15:0] s1_err;
  logic signed [16:0] s1_dd;

  always_comb begin
    diff = $signed({1'b0, req.count}) - $signed({9'b0, req.target});
    if (diff > 17'sd32767) begin
      err = 16'sh7fff;
    end else if (diff < -17'sd32768) begin
      err = 16'sh8000;
    end else begin
      err = diff[15:0];
    end
    dd = $signed({err[15], err}) - $signed({req.perr[15], req.perr});
  end

  // Stage 2: gain products.
  logic signed [24:0] p_full;
  logic signed [25:0] d_full;

  logic               s2_valid;
  logic [IDX_W-1:0]   s2_idx;
  logic               s2_run;
  logic [7:0]         s2_duty;
  logic signed [15:0] s2_err;
  logic signed [24:0] s2_p;
  logic signed [25:0] s2_d;

  assign p_full = $signed({1'b0, gains.prop}) * s1_err;
  assign d_full = $signed({1'b0, gains.deriv}) * s1_dd;

  // Stage 3: magnitudes and partial products of the reciprocal multiply.
  logic [24:0]                   p_abs;
  logic [25:0]                   d_abs;
  logic [dmpd_pkg::DIV_Y_W-1:0]  p_y;
  logic [dmpd_pkg::DIV_Y_W-1:0]  d_y;
  logic [dmpd_pkg::DIV_PP_W-1:0] p_lo;
  logic [dmpd_pkg::DIV_PP_W-1:0] p_hi;
  logic [dmpd_pkg::DIV_PP_W-1:0] d_lo;
  logic [dmpd_pkg::DIV_PP_W-1:0] d_hi;

  logic                          s3_valid;
  logic [IDX_W-1:0]              s3_idx;
  logic                          s3_run;
  logic [7:0]                    s3_duty;
  logic signed [15:0]            s3_err;
  logic                          s3_pneg;
  logic                          s3_dneg;
  logic [dmpd_pkg::DIV_PP_W-1:0] s3_plo;
  logic [dmpd_pkg::DIV_PP_W-1:0] s3_phi;
  logic [dmpd_pkg::DIV_PP_W-1:0] s3_dlo;
  logic [dmpd_pkg::DIV_PP_W-1:0] s3_dhi;

  always_comb begin
    p_abs = s2_p[24] ? 25'(-s2_p) : 25'(s2_p);
    d_abs = s2_d[25] ? 26'(-s2_d) : 26'(s2_d);
    p_y   = p_abs[dmpd_pkg::DIV_MAG_W-1:2];
    d_y   = d_abs[dmpd_pkg::DIV_MAG_W-1:2];
    p_lo  = dmpd_pkg::DIV_PP_W'(p_y[dmpd_pkg::DIV_HALF_W-1:0])
          * dmpd_pkg::DIV_PP_W'(dmpd_pkg::DIV_RECIP);
    p_hi  = dmpd_pkg::DIV_PP_W'(p_y[dmpd_pkg::DIV_Y_W-1:dmpd_pkg::DIV_HALF_W])
          * dmpd_pkg::DIV_PP_W'(dmpd_pkg::DIV_RECIP);
    d_lo  = dmpd_pkg::DIV_PP_W'(d_y[dmpd_pkg::DIV_HALF_W-1:0])
          * dmpd_pkg::DIV_PP_W'(dmpd_pkg::DIV_RECIP);
    d_hi  = dmpd_pkg::DIV_PP_W'(d_y[dmpd_pkg::DIV_Y_W-1:dmpd_pkg::DIV_HALF_W])
          * dmpd_pkg::DIV_PP_W'(dmpd_pkg::DIV_RECIP);
  end

  // Stage 4: quotients with the sign restored (truncation toward zero).
  logic [dmpd_pkg::DIV_SUM_W-1:0] p_sum;
  logic [dmpd_pkg::DIV_SUM_W-1:0] d_sum;
  logic [dmpd_pkg::DIV_Q_W-1:0]   p_q;
  logic [dmpd_pkg::DIV_Q_W-1:0]   d_q;
  logic signed [dmpd_pkg::DIV_Q_W:0] p_sq;
  logic signed [dmpd_pkg::DIV_Q_W:0] d_sq;

  logic                              s4_valid;
  logic [IDX_W-1:0]                  s4_idx;
  logic                              s4_run;
  logic [7:0]                        s4_duty;
  logic signed [15:0]                s4_err;
  logic signed [dmpd_pkg::DIV_Q_W:0] s4_qp;
  logic signed [dmpd_pkg::DIV_Q_W:0] s4_qd;

  always_comb begin
    p_sum = dmpd_pkg::DIV_SUM_W'(s3_plo)
          + (dmpd_pkg::DIV_SUM_W'(s3_phi) << dmpd_pkg::DIV_HALF_W);
    d_sum = dmpd_pkg::DIV_SUM_W'(s3_dlo)
          + (dmpd_pkg::DIV_SUM_W'(s3_dhi) << dmpd_pkg::DIV_HALF_W);
    p_q   = p_sum[dmpd_pkg::DIV_SHIFT +: dmpd_pkg::DIV_Q_W];
    d_q   = d_sum[dmpd_pkg::DIV_SHIFT +: dmpd_pkg::DIV_Q_W];
    p_sq  = s3_pneg ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});
    d_sq  = s3_dneg ? -$signed({1'b0, d_q}) : $signed({1'b0, d_q});
  end

  // Pipeline registers: valid bits are reset, payload is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= req_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx  <= req_idx;
    s1_run  <= req.run;
    s1_duty <= req.duty;
    s1_err  <= err;
    s1_dd   <= dd;

    s2_idx  <= s1_idx;
    s2_run  <= s1_run;
    s2_duty <= s1_duty;
    s2_err  <= s1_err;
    s2_p    <= p_full;
    s2_d    <= d_full;

    s3_idx  <= s2_idx;
    s3_run  <= s2_run;
    s3_duty <= s2_duty;
    s3_err  <= s2_err;
    s3_pneg <= s2_p[24];
    s3_dneg <= s2_d[25];
    s3_plo  <= p_lo;
    s3_phi  <= p_hi;
    s3_dlo  <= d_lo;
    s3_dhi  <= d_hi;

    s4_idx  <= s3_idx;
    s4_run  <= s3_run;
    s4_duty <= s3_duty;
    s4_err  <= s3_err;
    s4_qp   <= p_sq;
    s4_qd   <= d_sq;
  end

  // Final step: subtract the correction from the duty and saturate.
  logic signed [dmpd_pkg::DIV_Q_W+1:0] delta;
  logic signed [dmpd_pkg::DIV_Q_W+2:0] duty_raw;
  logic [7:0]                          duty_sat;

  always_comb begin
    delta    = $signed({s4_qp[dmpd_pkg::DIV_Q_W], s4_qp})
             + $signed({s4_qd[dmpd_pkg::DIV_Q_W], s4_qd});
    duty_raw = $signed({{(dmpd_pkg::DIV_Q_W - 5){1'b0}}, s4_duty})
             - $signed({delta[dmpd_pkg::DIV_Q_W+1], delta});
    if (duty_raw < 0) begin
      duty_sat = 8'd0;
    end else if (duty_raw > $signed({{(dmpd_pkg::DIV_Q_W - 5){1'b0}}, dmpd_pkg::DUTY_MAX})) begin
      duty_sat = dmpd_pkg::DUTY_MAX;
    end else begin
      duty_sat = duty_raw[7:0];
    end
  end

  // A stopped motor keeps its duty and forgets its previous error.
  assign rsp_valid = s4_valid;
  assign rsp_idx   = s4_idx;
  assign rsp.duty  = s4_run ? duty_sat : s4_duty;
  assign rsp.perr  = s4_run ? s4_err : 16'sd0;

endmodule

[tb/dual_motor_pd_speed_regulator_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_pd_speed_regulator_core_tb
// Self-checking bench for the dual motor PD speed regulator. A directed table
// covers reset values, every action and the corner cases. An encoder burst
// drives a large error that pulls the duty to its floor. Randomized control
// periods then run under several gain settings. Every result word is compared,
// field by field, with a pinned row's typed-in result or the bench's model of both motors.
// ----------------------------------------------------------------------------
module dual_motor_pd_speed_regulator_core_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int REPORT_MAX     = 10;
  localparam int SPEED_CODES    = 16;
  localparam int PERIOD_WORDS   = 145;
  localparam int BURST_EDGES    = 300;
  localparam logic [7:0] GAIN_P_RESET = 8'd60;
  localparam logic [7:0] GAIN_D_RESET = 8'd30;

  // Target pulse counts per speed code.
  localparam logic [7:0] TARGET_TABLE [SPEED_CODES] = '{
    8'd0, 8'd10, 8'd20, 8'd28, 8'd36, 8'd46, 8'd54, 8'd66,
    8'd74, 8'd84, 8'd92, 8'd102, 8'd112, 8'd122, 8'd130, 8'd140
  };

  // One result word, in port order.
  typedef struct packed {
    logic [7:0] duty_a;
    logic [7:0] duty_b;
    logic [1:0] dir_a;
    logic [1:0] dir_b;
    logic [1:0] pins_a;
    logic [1:0] pins_b;
    logic [1:0] enable;
  } motor_status_t;

  // One row of the directed table; pinned rows carry a typed-in result.
  typedef struct packed {
    logic [1:0]    act;
    logic          sel;
    logic [7:0]    val;
    logic          pinned;
    motor_status_t res;
  } stim_row_t;

  localparam motor_status_t ALL_STOPPED =
    '{8'd0, 8'd0, dmpd_pkg::DIR_STOP, dmpd_pkg::DIR_STOP,
      dmpd_pkg::PINS_BRAKE, dmpd_pkg::PINS_BRAKE, 2'b00};
  localparam motor_status_t FIRST_RUNNING =
    '{8'd0, 8'd0, dmpd_pkg::DIR_FWD, dmpd_pkg::DIR_STOP,
      dmpd_pkg::PINS_FWD, dmpd_pkg::PINS_BRAKE, 2'b01};
  localparam motor_status_t BOTH_RUNNING =
    '{8'd0, 8'd0, dmpd_pkg::DIR_FWD, dmpd_pkg::DIR_BWD,
      dmpd_pkg::PINS_FWD, dmpd_pkg::PINS_BWD, 2'b11};

  // Clock and block ports.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = dmpd_pkg::ACT_EDGE;
  logic motor_select = 1'b0;
  logic [7:0] command_value = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] duty_first, duty_second;
  logic [1:0] dir_first, dir_second;
  logic [1:0] bridge_pins_first, bridge_pins_second;
  logic [1:0] pwm_enable_mask;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dmpd_pkg::CFG_IDX_W-1:0] cfg_index = dmpd_pkg::REG_PROP_GAIN;
  logic [7:0] cfg_data = 8'd0;

  // Bench control.
  logic calm_phase = 1'b0;
  logic pinned_use = 1'b0;
  motor_status_t pinned_status = ALL_STOPPED;
  int stall_left = 0;
  int idle_cnt = 0;
  int mismatch_cnt = 0;
  int results_seen = 0;
  logic drv_running [2] = '{1'b0, 1'b0};
  int drv_target [2] = '{0, 0};

  // Model state of both motors.
  logic [7:0] gain_p, gain_d;
  logic [15:0] pulse_cnt [2];
  logic [7:0] target_cnt [2];
  int prev_err [2];
  logic [7:0] duty_val [2];
  logic [1:0] run_dir [2];
  motor_status_t pending_status [$];

  always #5 clk = ~clk;

  dual_motor_pd_speed_regulator_core uut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .action             (action),
    .motor_select       (motor_select),
    .command_value      (command_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .duty_first         (duty_first),
    .duty_second        (duty_second),
    .dir_first          (dir_first),
    .dir_second         (dir_second),
    .bridge_pins_first  (bridge_pins_first),
    .bridge_pins_second (bridge_pins_second),
    .pwm_enable_mask    (pwm_enable_mask),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Apply one word to the motor model and return the status it reports.
  function automatic motor_status_t step_regulator(input logic [1:0] act,
                                                   input logic sel,
                                                   input logic [7:0] val);
    motor_status_t st;
    int err, delta, level, gp, gd;
    gp = gain_p;
    gd = gain_d;
    case (act)
      dmpd_pkg::ACT_TICK: begin
        for (int k = 0; k < 2; k++) begin
          if (run_dir[k] == dmpd_pkg::DIR_STOP) begin
            prev_err[k] = 0;
          end else begin
            err = int'(pulse_cnt[k]) - int'(target_cnt[k]);
            if (err > 32767) err = 32767;
            if (err < -32768) err = -32768;
            delta = (gp * err) / 100 + (gd * (err - prev_err[k])) / 100;
            prev_err[k] = err;
            level = int'(duty_val[k]) - delta;
            if (level < 0) level = 0;
            if (level > 255) level = 255;
            duty_val[k] = level[7:0];
          end
        end
        for (int k = 0; k < 2; k++) pulse_cnt[k] = 16'd0;
      end
      dmpd_pkg::ACT_EDGE: begin
        if (run_dir[sel] != dmpd_pkg::DIR_STOP) pulse_cnt[sel] = pulse_cnt[sel] + 16'd1;
      end
      dmpd_pkg::ACT_SPEED: begin
        target_cnt[sel] = TARGET_TABLE[4'(val % SPEED_CODES)];
      end
      default: begin
        // Anything but forward or backward stops the motor with the brake on.
        if (val == dmpd_pkg::DIR_FWD || val == dmpd_pkg::DIR_BWD) begin
          run_dir[sel] = val[1:0];
          pulse_cnt[sel] = 16'd0;
        end else begin
          run_dir[sel] = dmpd_pkg::DIR_STOP;
        end
      end
    endcase
    st.duty_a = duty_val[0];
    st.duty_b = duty_val[1];
    st.dir_a  = run_dir[0];
    st.dir_b  = run_dir[1];
    st.pins_a = (run_dir[0] == dmpd_pkg::DIR_FWD) ? dmpd_pkg::PINS_FWD :
                (run_dir[0] == dmpd_pkg::DIR_BWD) ? dmpd_pkg::PINS_BWD :
                dmpd_pkg::PINS_BRAKE;
    st.pins_b = (run_dir[1] == dmpd_pkg::DIR_FWD) ? dmpd_pkg::PINS_FWD :
                (run_dir[1] == dmpd_pkg::DIR_BWD) ? dmpd_pkg::PINS_BWD :
                dmpd_pkg::PINS_BRAKE;
    st.enable = {run_dir[1] != dmpd_pkg::DIR_STOP, run_dir[0] != dmpd_pkg::DIR_STOP};
    return st;
  endfunction

  // Track gain writes and accepted words in the model.
  always @(posedge clk) begin : model_update
    motor_status_t predicted;
    if (rst) begin
      gain_p = GAIN_P_RESET;
      gain_d = GAIN_D_RESET;
      for (int k = 0; k < 2; k++) begin
        pulse_cnt[k] = 16'd0;
        target_cnt[k] = 8'd0;
        prev_err[k] = 0;
        duty_val[k] = 8'd0;
        run_dir[k] = dmpd_pkg::DIR_STOP;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dmpd_pkg::REG_PROP_GAIN:  gain_p = cfg_data;
          dmpd_pkg::REG_DERIV_GAIN: gain_d = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predicted = step_regulator(action, motor_select, command_value);
        pending_status.push_back(pinned_use ? pinned_status : predicted);
      end
    end
  end

  function automatic void check_field(input string label, input logic [7:0] want,
                                      input logic [7:0] seen);
    if (seen !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX)
        $display("result word %0d: %s expected %0d, got %0d",
                 results_seen, label, want, seen);
    end
  endfunction

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin : result_check
    motor_status_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_status.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("result word %0d arrived with nothing expected", results_seen);
      end else begin
        want = pending_status.pop_front();
        check_field("duty_first", want.duty_a, duty_first);
        check_field("duty_second", want.duty_b, duty_second);
        check_field("dir_first", want.dir_a, dir_first);
        check_field("dir_second", want.dir_b, dir_second);
        check_field("bridge_pins_first", want.pins_a, bridge_pins_first);
        check_field("bridge_pins_second", want.pins_b, bridge_pins_second);
        check_field("pwm_enable_mask", want.enable, pwm_enable_mask);
      end
      results_seen++;
    end
  end

  // Result side back-pressure: mostly short stalls, a few long ones.
  always @(posedge clk) begin : stall_gen
    int r;
    r = $urandom_range(0, 99);
    if (calm_phase) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (r < 70) begin
      out_stall <= 1'b0;
    end else if (r < 95) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(10, 40);
    end
  end

  // End the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_phase || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one word and hold it until it is taken.
  task automatic send_word(input logic [1:0] act, input logic sel, input logic [7:0] val,
                           input logic pin, input motor_status_t pin_res);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    motor_select <= sel;
    command_value <= val;
    pinned_use <= pin;
    pinned_status <= pin_res;
    if (act == dmpd_pkg::ACT_DIR)
      drv_running[sel] = (val == dmpd_pkg::DIR_FWD || val == dmpd_pkg::DIR_BWD);
    if (act == dmpd_pkg::ACT_SPEED) drv_target[sel] = TARGET_TABLE[4'(val % SPEED_CODES)];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_plain(input logic [1:0] act, input logic sel, input logic [7:0] val);
    send_word(act, sel, val, 1'b0, ALL_STOPPED);
  endtask

  // Stop sending and wait until every expected word has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_gains(input logic [7:0] p, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= dmpd_pkg::REG_PROP_GAIN;
    cfg_data <= p;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= dmpd_pkg::REG_DERIV_GAIN;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Control periods: optional commands, about a target's worth of encoder
  // edges per running motor, then a tick. Some words are plain noise.
  task automatic run_control_periods(input int wanted);
    int done_items, m, r, code;
    int edges_left [2];
    logic [7:0] dir_code;
    done_items = 0;
    while (done_items < wanted) begin
      if ($urandom_range(0, 99) < 12) begin
        r = $urandom_range(0, 3);
        m = $urandom_range(0, 1);
        done_items++;
        send_plain(r[1:0], m[0], 8'($urandom));
      end else begin
        for (m = 0; m < 2; m++) begin
          if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(0, 9);
            dir_code = (r < 4) ? 8'(dmpd_pkg::DIR_FWD) : (r < 8) ? 8'(dmpd_pkg::DIR_BWD) :
                       (r == 8) ? 8'(dmpd_pkg::DIR_STOP) : 8'($urandom_range(3, 255));
            send_plain(dmpd_pkg::ACT_DIR, m[0], dir_code);
            done_items++;
          end
          if ($urandom_range(0, 3) == 0) begin
            code = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, 15);
            send_plain(dmpd_pkg::ACT_SPEED, m[0], {4'($urandom), 4'(code)});
            done_items++;
          end
        end
        for (m = 0; m < 2; m++) begin
          if (!drv_running[m])
            edges_left[m] = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
          else if ($urandom_range(0, 4) == 0)
            edges_left[m] = $urandom_range(0, 2 * drv_target[m] + 20);
          else
            edges_left[m] = drv_target[m] + int'($urandom_range(0, 16)) - 8;
          if (edges_left[m] < 0) edges_left[m] = 0;
        end
        while ((edges_left[0] + edges_left[1] > 0) && (done_items < wanted)) begin
          m = (edges_left[0] == 0) ? 1 : (edges_left[1] == 0) ? 0 : $urandom_range(0, 1);
          edges_left[m]--;
          done_items++;
          send_plain(dmpd_pkg::ACT_EDGE, m[0], 8'($urandom));
        end
        send_plain(dmpd_pkg::ACT_TICK, 1'($urandom), 8'($urandom));
        done_items++;
        if ($urandom_range(0, 49) == 0) wait_for_results();
      end
    end
  endtask

  initial begin : stimulus
    stim_row_t directed_rows [23];
    logic [7:0] plan_p [7];
    logic [7:0] plan_d [7];

    // Reset state first, then every action and the corner cases.
    directed_rows = '{
      '{dmpd_pkg::ACT_EDGE,  1'b0, 8'h00, 1'b1, ALL_STOPPED},   // edge on a stopped motor
      '{dmpd_pkg::ACT_EDGE,  1'b1, 8'hff, 1'b1, ALL_STOPPED},
      '{dmpd_pkg::ACT_TICK,  1'b1, 8'ha5, 1'b1, ALL_STOPPED},   // tick with both stopped
      '{dmpd_pkg::ACT_SPEED, 1'b0, 8'hff, 1'b1, ALL_STOPPED},   // highest speed code
      '{dmpd_pkg::ACT_SPEED, 1'b1, 8'h10, 1'b1, ALL_STOPPED},   // upper bits ignored
      '{dmpd_pkg::ACT_DIR,   1'b0, 8'h01, 1'b1, FIRST_RUNNING},
      '{dmpd_pkg::ACT_DIR,   1'b1, 8'h02, 1'b1, BOTH_RUNNING},
      '{dmpd_pkg::ACT_EDGE,  1'b0, 8'h00, 1'b0, ALL_STOPPED},
      '{dmpd_pkg::ACT_EDGE,  1'b1, 8'h80, 1'b0, ALL_STOPPED},
      '{dmpd_pkg::ACT_TICK,  1'b0, 8'h00, 1'b0, ALL_STOPPED},
      '{dmpd_pkg::ACT_TICK,  1'b1, 8'hff, 1'b0, ALL_STOPPED},
      '{dmpd_pkg::ACT_TICK,  1'b0, 8'h5a, 1'b0, ALL_STOPPED},   // duty runs into the top
      '{dmpd_pkg::ACT_SPEED, 1'b0, 8'hf3, 1'b0, ALL_STOPPED},
      '{dmpd_pkg::ACT_DIR,   1'b0, 8'h01, 1'b0, ALL_STOPPED},   // restart while running
      '{dmpd_pkg::ACT_EDGE,  1'b0, 8'h3c, 1'b0, ALL_STOPPED},
      '{dmpd_pkg::ACT_EDGE,  1'b0, 8'hc3, 1'b0, ALL_STOPPED},
      '{dmpd_pkg::ACT_DIR,   1'b1, 8'h00, 1'b0, ALL_STOPPED},   // explicit stop
      '{dmpd_pkg::ACT_EDGE,  1'b1, 8'h7f, 1'b0, ALL_STOPPED},
      '{dmpd_pkg::ACT_TICK,  1'b0, 8'h00, 1'b0, ALL_STOPPED},
      '{dmpd_pkg::ACT_DIR,   1'b1, 8'hff, 1'b0, ALL_STOPPED},   // unknown direction brakes
      '{dmpd_pkg::ACT_DIR,   1'b0, 8'h02, 1'b0, ALL_STOPPED},   // reverse while running
      '{dmpd_pkg::ACT_SPEED, 1'b1, 8'h0f, 1'b0, ALL_STOPPED},
      '{dmpd_pkg::ACT_TICK,  1'b1, 8'h00, 1'b0, ALL_STOPPED}
    };
    plan_p = '{8'd255, 8'd0, 8'd255, 8'd0, 8'($urandom), 8'($urandom), 8'd60};
    plan_d = '{8'd255, 8'd0, 8'd0, 8'd255, 8'($urandom), 8'($urandom), 8'd30};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].act, directed_rows[i].sel, directed_rows[i].val,
                directed_rows[i].pinned, directed_rows[i].res);

    // Encoder burst well past the target: the large error pulls the duty
    // down to its floor.
    wait_for_results();
    write_gains(8'd100, 8'd50);
    calm_phase <= 1'b1;
    send_plain(dmpd_pkg::ACT_DIR, 1'b0, 8'(dmpd_pkg::DIR_FWD));
    send_plain(dmpd_pkg::ACT_SPEED, 1'b0, 8'h0f);
    repeat (BURST_EDGES) send_plain(dmpd_pkg::ACT_EDGE, 1'b0, 8'($urandom));
    send_plain(dmpd_pkg::ACT_TICK, 1'b0, 8'($urandom));

    // Random control periods under each gain setting; one phase runs
    // without any idling.
    for (int ph = 0; ph < 7; ph++) begin
      wait_for_results();
      write_gains(plan_p[ph], plan_d[ph]);
      calm_phase <= (ph == 3);
      run_control_periods(PERIOD_WORDS);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_status.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
src/dmpd_pkg.sv
src/dmpd_pd_calc.sv
src/dual_motor_pd_speed_regulator_core.sv
tb/dual_motor_pd_speed_regulator_core_tb.sv
